@@ rtl/core/phc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// phc_pkg
// Shared types, register codes and ones-complement helpers for the
// pseudo-header transport checksum block.
// ----------------------------------------------------------------------------
package phc_pkg;

	localparam int unsigned WORD_W  = 16;
	localparam int unsigned SUM_W   = 32;
	localparam int unsigned BYTES_W = 17;
	localparam int unsigned ADDR_W  = 64;
	localparam int unsigned PROTO_W = 8;
	localparam int unsigned SRC_W   = 20;  // protocol plus up to eight address words
	localparam int unsigned DST_W   = 19;  // up to eight address words
	localparam int unsigned HSUM_W  = 21;  // source, destination and length
	localparam logic [PROTO_W-1:0] PROTO_RESET = 8'd17;
	localparam logic [BYTES_W-1:0] BYTES_MAX   = 17'h1FFFF;

	typedef enum logic [1:0] {
		CFG_IP_MODE  = 2'd0,
		CFG_PROTOCOL = 2'd1,
		CFG_SRC_HIGH = 2'd2,
		CFG_SRC_LOW  = 2'd3
	} cfg_idx_t;

	// configuration view handed to the datapath
	typedef struct packed {
		logic             ipv6;
		logic [SRC_W-1:0] src_sum;
	} cfg_t;

	// end-around fold of a sum down to 16 bits
	function automatic logic [WORD_W-1:0] fold16(input logic [SUM_W-1:0] s);
		logic [WORD_W:0] t;
		logic [WORD_W:0] u;
		t = {1'b0, s[31:16]} + {1'b0, s[15:0]};
		u = t + {{WORD_W{1'b0}}, t[WORD_W]};
		return u[WORD_W-1:0];
	endfunction

	function automatic logic [17:0] words64(input logic [ADDR_W-1:0] v);
		return {2'b0, v[63:48]} + {2'b0, v[47:32]} + {2'b0, v[31:16]} + {2'b0, v[15:0]};
	endfunction

	function automatic logic [16:0] words32(input logic [ADDR_W-1:0] v);
		return {1'b0, v[31:16]} + {1'b0, v[15:0]};
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/phc_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// phc_in_if
// Payload word channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface phc_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] payload_word;
	logic [1:0]  byte_count;
	logic        last;
	logic [63:0] dest_high;
	logic [63:0] dest_low;

	modport source (output valid, payload_word, byte_count, last, dest_high, dest_low,
		input ready);
	modport sink (input valid, payload_word, byte_count, last, dest_high, dest_low,
		output ready);
endinterface
`default_nettype wire

@@ rtl/core/phc_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// phc_out_if
// Checksum result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface phc_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] checksum;
	logic        length_overflow;

	modport source (output valid, checksum, length_overflow, input ready);
	modport sink (input valid, checksum, length_overflow, output ready);
endinterface
`default_nettype wire

@@ rtl/core/phc_cfg_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// phc_cfg_regs
// Configuration registers with a registered pseudo-header source sum
// (source address words plus protocol).
// ----------------------------------------------------------------------------
module phc_cfg_regs
	import phc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [ADDR_W-1:0]  cfg_wdata,
	output cfg_t                    cfg
);

	logic               ipv6_q;
	logic [PROTO_W-1:0] proto_q;
	logic [ADDR_W-1:0]  src_high_q;
	logic [ADDR_W-1:0]  src_low_q;
	logic [SRC_W-1:0]   src_sum_q;
	logic [SRC_W-1:0]   src_sum_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ipv6_q     <= 1'b0;
			proto_q    <= PROTO_RESET;
			src_high_q <= '0;
			src_low_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_IP_MODE:  ipv6_q     <= cfg_wdata[0];
				CFG_PROTOCOL: proto_q    <= cfg_wdata[PROTO_W-1:0];
				CFG_SRC_HIGH: src_high_q <= cfg_wdata;
				CFG_SRC_LOW:  src_low_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (ipv6_q) begin
			src_sum_d = {2'b0, words64(src_high_q)} + {2'b0, words64(src_low_q)}
				+ {12'b0, proto_q};
		end else begin
			src_sum_d = {3'b0, words32(src_low_q)} + {12'b0, proto_q};
		end
	end

	// registered from the configuration registers, settled before any item needs it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_sum_q <= {12'b0, PROTO_RESET};
		end else begin
			src_sum_q <= src_sum_d;
		end
	end

	assign cfg.ipv6    = ipv6_q;
	assign cfg.src_sum = src_sum_q;

endmodule
`default_nettype wire

@@ rtl/core/pseudo_header_transport_checksum.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pseudo_header_transport_checksum
// TCP/UDP/ICMP checksum over a streamed payload with IPv4/IPv6 pseudo header.
// ----------------------------------------------------------------------------
// Takes one payload word per cycle unless stalled from the output; a last
// item waits in stage 1 until stage 2 can take it. Each accepted item is
// added into a running word sum and byte count. The item marked last goes
// through the stage 2 packet totals, the stage 3 complemented folds and the
// result register to the output, and the stream state clears for the next
// packet. The destination address sum is formed in stage 1; the
// pseudo-header sum and the end-around folds sit in the following stages.
// Configuration writes take effect for items accepted from the next cycle.
// ----------------------------------------------------------------------------
module pseudo_header_transport_checksum
	import phc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	phc_in_if.sink                 in_ch,
	phc_out_if.source              out_ch,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [ADDR_W-1:0] cfg_wdata
);

	cfg_t cfg;

	phc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// stage 1: input register
	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic [1:0]        cnt_s1;
	logic              last_s1;
	logic [ADDR_W-1:0] dhi_s1;
	logic [ADDR_W-1:0] dlo_s1;

	// stream state
	logic [SUM_W-1:0]   sum_q;
	logic [BYTES_W-1:0] bytes_q;

	// stage 2: packet totals
	logic               valid_s2;
	logic [SUM_W-1:0]   psum_s2;
	logic [BYTES_W-1:0] bytes_s2;
	logic [DST_W-1:0]   dsum_s2;

	// stage 3: complemented folds
	logic              valid_s3;
	logic [WORD_W-1:0] sumh_s3;
	logic [WORD_W-1:0] sumd_s3;
	logic              ovf_s3;

	// result register
	logic              out_valid_q;
	logic [WORD_W-1:0] checksum_q;
	logic              ovf_q;

	logic rdy_o, rdy3, rdy2, rdy1, move1;

	assign rdy_o = !out_valid_q || out_ch.ready;
	assign rdy3  = !valid_s3 || rdy_o;
	assign rdy2  = !valid_s2 || rdy3;
	// non-last items retire into the accumulator without needing stage 2
	assign move1 = valid_s1 && (!last_s1 || rdy2);
	assign rdy1  = !valid_s1 || move1;

	assign in_ch.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy1) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_ch.valid) begin
			word_s1 <= in_ch.payload_word;
			cnt_s1  <= in_ch.byte_count;
			last_s1 <= in_ch.last;
			dhi_s1  <= in_ch.dest_high;
			dlo_s1  <= in_ch.dest_low;
		end
	end

	// accumulate
	logic [WORD_W-1:0]  word_add;
	logic [1:0]         cnt_add;
	logic [BYTES_W:0]   bytes_sum;
	logic [BYTES_W-1:0] bytes_next;
	logic [SUM_W-1:0]   sum_next;
	logic [DST_W-1:0]   dsum_d;

	always_comb begin
		case (cnt_s1)
			2'd0: begin
				word_add = '0;
				cnt_add  = 2'd0;
			end
			2'd1: begin
				// odd byte padded as high byte
				word_add = {word_s1[15:8], 8'h00};
				cnt_add  = 2'd1;
			end
			default: begin
				word_add = word_s1;
				cnt_add  = 2'd2;
			end
		endcase
		bytes_sum  = {1'b0, bytes_q} + {{(BYTES_W-1){1'b0}}, cnt_add};
		bytes_next = bytes_sum[BYTES_W] ? BYTES_MAX : bytes_sum[BYTES_W-1:0];
		sum_next   = sum_q + {{(SUM_W-WORD_W){1'b0}}, word_add};
		if (cfg.ipv6) begin
			dsum_d = {1'b0, words64(dhi_s1)} + {1'b0, words64(dlo_s1)};
		end else begin
			dsum_d = {2'b0, words32(dlo_s1)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			bytes_q <= '0;
		end else if (move1) begin
			if (last_s1) begin
				sum_q   <= '0;
				bytes_q <= '0;
			end else begin
				sum_q   <= sum_next;
				bytes_q <= bytes_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy2) begin
			valid_s2 <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move1 && last_s1) begin
			psum_s2  <= sum_next;
			bytes_s2 <= bytes_next;
			dsum_s2  <= dsum_d;
		end
	end

	// pseudo-header sum and folds
	logic [HSUM_W-1:0] hsum;

	assign hsum = {1'b0, cfg.src_sum} + {2'b0, dsum_s2}
		+ {{(HSUM_W-WORD_W){1'b0}}, bytes_s2[WORD_W-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && valid_s2) begin
			sumh_s3 <= ~fold16({{(SUM_W-HSUM_W){1'b0}}, hsum});
			sumd_s3 <= ~fold16(psum_s2);
			ovf_s3  <= bytes_s2[BYTES_W-1];
		end
	end

	// final add with end-around fold
	logic [WORD_W:0] final_sum;

	assign final_sum = {1'b0, sumh_s3} + {1'b0, sumd_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_o) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o && valid_s3) begin
			checksum_q <= fold16({{(SUM_W-WORD_W-1){1'b0}}, final_sum});
			ovf_q      <= ovf_s3;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.checksum        = checksum_q;
	assign out_ch.length_overflow = ovf_q;

endmodule
`default_nettype wire

@@ tb/pseudo_header_transport_checksum_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pseudo_header_transport_checksum_tb
// Drives payload words into the transport checksum block, predicts every
// checksum and overflow flag from an internal ones-complement sum model,
// and compares each result in order under random idling and backpressure.
// ----------------------------------------------------------------------------
module pseudo_header_transport_checksum_tb;
	import phc_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 2_000_000;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned PHASE_ITEMS  = 250;

	typedef struct packed {
		logic [15:0] checksum;
		logic        length_overflow;
	} csum_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [ADDR_W-1:0] cfg_wdata;

	phc_in_if  in_ch();
	phc_out_if out_ch();

	pseudo_header_transport_checksum dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// predictor copy of configuration and packet state
	logic        cfg_ipv6;
	logic [7:0]  cfg_proto;
	logic [63:0] cfg_src_hi;
	logic [63:0] cfg_src_lo;
	logic [31:0] acc_sum;
	logic [16:0] acc_bytes;

	csum_result_t pending_sums[$];
	int unsigned  mismatch_count = 0;
	int unsigned  cycle_count = 0;
	int unsigned  hold_off_cycles = 0;
	bit           src_idle = 1'b1;
	bit           sink_idle = 1'b1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("pseudo_header_transport_checksum: mismatch");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// payload words biased toward the carry-heavy extremes
	function automatic logic [15:0] pick_word();
		int unsigned sel;
		sel = $urandom_range(0, 7);
		if (sel == 0)
			return 16'hFFFF;
		if (sel == 1)
			return 16'h0000;
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] ones_fold(input logic [31:0] s);
		logic [31:0] t;
		t = {16'h0, s[31:16]} + {16'h0, s[15:0]};
		t = t + {16'h0, t[31:16]};
		return t[15:0];
	endfunction

	// sum of the lowest n 16-bit words of an address half
	function automatic logic [31:0] word_sum(input logic [63:0] v, input int unsigned n);
		logic [31:0] s;
		s = '0;
		for (int unsigned k = 0; k < n; k++)
			s = s + {16'h0, v[16*k +: 16]};
		return s;
	endfunction

	task automatic predict_checksum(input logic [15:0] word, input logic [1:0] cnt,
			input logic last, input logic [63:0] dhi, input logic [63:0] dlo);
		logic [15:0]  w;
		logic [1:0]   n;
		logic [17:0]  bytes_next;
		logic [31:0]  hdr;
		logic [15:0]  hdr_inv;
		logic [15:0]  data_inv;
		csum_result_t res;
		n = (cnt == 2'd3) ? 2'd2 : cnt;
		// odd byte is the high byte of a zero-padded word
		w = (n == 2'd1) ? {word[15:8], 8'h00} : word;
		if (n != 2'd0) begin
			acc_sum = acc_sum + {16'h0, w};
			bytes_next = {1'b0, acc_bytes} + {16'h0, n};
			acc_bytes = (bytes_next > 18'h1FFFF) ? 17'h1FFFF : bytes_next[16:0];
		end
		if (last) begin
			if (!cfg_ipv6) begin
				hdr = {24'h0, cfg_proto} + {16'h0, acc_bytes[15:0]}
					+ word_sum(cfg_src_lo, 2) + word_sum(dlo, 2);
			end else begin
				hdr = word_sum(cfg_src_hi, 4) + word_sum(cfg_src_lo, 4)
					+ word_sum(dhi, 4) + word_sum(dlo, 4)
					+ {16'h0, acc_bytes[15:0]} + {24'h0, cfg_proto};
			end
			hdr_inv = ~ones_fold(hdr);
			data_inv = ~ones_fold(acc_sum);
			res.checksum = ones_fold({16'h0, hdr_inv} + {16'h0, data_inv});
			res.length_overflow = acc_bytes[16];
			pending_sums.push_back(res);
			acc_sum = '0;
			acc_bytes = '0;
		end
	endtask

	task automatic send_word(input logic [15:0] word, input logic [1:0] cnt, input logic last,
			input logic [63:0] dhi, input logic [63:0] dlo);
		int unsigned gap;
		gap = src_idle ? $urandom_range(0, 3) : 0;
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.payload_word <= word;
		in_ch.byte_count <= cnt;
		in_ch.last <= last;
		in_ch.dest_high <= dhi;
		in_ch.dest_low <= dlo;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		predict_checksum(word, cnt, last, dhi, dlo);
	endtask

	// block goes quiet: no item offered, every checksum back, pipeline flushed
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (pending_sums.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// writes all four registers; unused upper data bits carry noise
	task automatic set_config(input logic mode, input logic [7:0] proto,
			input logic [63:0] src_hi, input logic [63:0] src_lo);
		logic [63:0] noise;
		noise = rand64();
		cfg_we <= 1'b1;
		cfg_index <= CFG_IP_MODE;
		cfg_wdata <= {noise[63:1], mode};
		@(posedge clk);
		cfg_index <= CFG_PROTOCOL;
		cfg_wdata <= {noise[63:8], proto};
		@(posedge clk);
		cfg_index <= CFG_SRC_HIGH;
		cfg_wdata <= src_hi;
		@(posedge clk);
		cfg_index <= CFG_SRC_LOW;
		cfg_wdata <= src_lo;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_ipv6 = mode;
		cfg_proto = proto;
		cfg_src_hi = src_hi;
		cfg_src_lo = src_lo;
	endtask

	// well-formed packet: full words then a last item of any size; noisy
	// packets also use short and empty words in the middle
	task automatic send_packet(input int unsigned len, input bit noisy);
		logic [1:0] cnt;
		logic       last;
		for (int unsigned i = 0; i < len; i++) begin
			last = (i == len - 1);
			cnt = (last || noisy) ? 2'($urandom_range(0, 3)) : 2'd2;
			send_word(pick_word(), cnt, last, rand64(), rand64());
		end
	endtask

	task automatic test_reset_defaults();
		send_word(16'h0000, 2'd2, 1'b0, rand64(), rand64());
		send_word(16'hFFFF, 2'd2, 1'b0, rand64(), rand64());
		send_word(16'hABCD, 2'd1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_C0A8_0001);
		// empty packet
		send_word(16'hFFFF, 2'd0, 1'b1, 64'h0, 64'h0);
		wait_idle();
	endtask

	task automatic test_byte_counts();
		set_config(1'b0, 8'd6, rand64(), 64'hDEAD_BEEF_0A00_0001);
		send_word(16'h1234, 2'd3, 1'b0, rand64(), rand64());
		send_word(16'h5678, 2'd1, 1'b0, rand64(), rand64());
		send_word(16'h9ABC, 2'd0, 1'b0, rand64(), rand64());
		send_word(16'hFFFF, 2'd2, 1'b0, rand64(), rand64());
		send_word(16'h00FF, 2'd1, 1'b1, rand64(), 64'hFFFF_FFFF_0A00_0002);
		wait_idle();
	endtask

	task automatic test_ipv6_extremes();
		set_config(1'b1, 8'd255, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		repeat (3) send_word(16'hFFFF, 2'd2, 1'b0, rand64(), rand64());
		send_word(16'hFFFF, 2'd3, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_word(16'h0000, 2'd0, 1'b1, 64'h0, 64'h0);
		wait_idle();
		set_config(1'b1, 8'd0, 64'h0, 64'h0);
		send_word(16'h0000, 2'd2, 1'b1, 64'h0, 64'h0);
		send_word(16'hFFFF, 2'd1, 1'b1, 64'h0, 64'h0);
		wait_idle();
	endtask

	task automatic test_long_payload();
		set_config(1'b0, 8'd6, rand64(), rand64());
		src_idle = 1'b0;
		// exactly 65535 bytes: largest length without overflow
		repeat (32767) send_word(pick_word(), 2'd2, 1'b0, rand64(), rand64());
		send_word(pick_word(), 2'd1, 1'b1, rand64(), rand64());
		// all-ones words: sum wraps, length overflows and then saturates
		repeat (66000) send_word(16'hFFFF, 2'd2, 1'b0, rand64(), rand64());
		send_word(pick_word(), 2'd2, 1'b1, rand64(), rand64());
		src_idle = 1'b1;
		wait_idle();
	endtask

	task automatic test_backpressure();
		set_config(1'b1, 8'($urandom), rand64(), rand64());
		src_idle = 1'b0;
		hold_off_cycles = HOLD_CYCLES;
		// one-item packets so every item makes a result and the block fills
		repeat (60) send_word(pick_word(), 2'($urandom_range(0, 3)), 1'b1, rand64(), rand64());
		src_idle = 1'b1;
		wait_idle();
		repeat (20) send_packet($urandom_range(1, 4), 1'b0);
		wait_idle();
	endtask

	task automatic test_random_traffic();
		int unsigned sent;
		int unsigned len;
		for (int unsigned phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_config(1'b0, 8'd0, 64'h0, 64'h0);
				1: set_config(1'b1, 8'd255, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
				2: set_config(1'b0, 8'hFF, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
				default: set_config(1'($urandom), 8'($urandom), rand64(), rand64());
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				src_idle = ($urandom_range(0, 3) != 0);
				sink_idle = ($urandom_range(0, 3) != 0);
				len = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
				send_packet(len, $urandom_range(0, 4) == 0);
				sent += len;
			end
			src_idle = 1'b1;
			sink_idle = 1'b1;
			wait_idle();
		end
	endtask

	// result side: random stalls per item, plus a long hold on request
	initial begin : result_sink
		int unsigned wait_n;
		out_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_off_cycles != 0) begin
				out_ch.ready <= 1'b0;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
			end else begin
				wait_n = sink_idle ? $urandom_range(0, 3) : 0;
				if (wait_n != 0) begin
					out_ch.ready <= 1'b0;
					repeat (wait_n) @(posedge clk);
				end
				out_ch.ready <= 1'b1;
				@(posedge clk);
				while (!out_ch.valid && hold_off_cycles == 0)
					@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_results
		csum_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_sums.size() == 0) begin
				$display("%0t: unexpected result checksum=%h length_overflow=%b", $time,
					out_ch.checksum, out_ch.length_overflow);
				mismatch_count++;
			end else begin
				want = pending_sums.pop_front();
				if (out_ch.checksum !== want.checksum) begin
					$display("%0t: checksum expected %h actual %h", $time,
						want.checksum, out_ch.checksum);
					mismatch_count++;
				end
				if (out_ch.length_overflow !== want.length_overflow) begin
					$display("%0t: length_overflow expected %b actual %b", $time,
						want.length_overflow, out_ch.length_overflow);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_IP_MODE;
		cfg_wdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.payload_word <= '0;
		in_ch.byte_count <= '0;
		in_ch.last <= 1'b0;
		in_ch.dest_high <= '0;
		in_ch.dest_low <= '0;
		cfg_ipv6 = 1'b0;
		cfg_proto = PROTO_RESET;
		cfg_src_hi = '0;
		cfg_src_lo = '0;
		acc_sum = '0;
		acc_bytes = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_byte_counts();
		test_ipv6_extremes();
		test_backpressure();
		test_random_traffic();
		test_long_payload();

		wait_idle();
		if (mismatch_count == 0)
			$display("pseudo_header_transport_checksum: match");
		else
			$display("pseudo_header_transport_checksum: mismatch");
		$finish;
	end

endmodule
`default_nettype wire
